@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/core/sspp_pkg.sv @@
// ----------------------------------------------------------------------------
// Servo status packet parser package
// Shared phase codes, constants and the per-byte result type.
// ----------------------------------------------------------------------------
`default_nettype none

package sspp_pkg;

    // Header byte that opens every status packet.
    localparam logic [7:0] HEADER_BYTE = 8'hFF;

    // Length bytes that do not count as parameters (error byte and checksum).
    localparam logic [7:0] LEN_OVERHEAD = 8'd2;

    // Parse phases, one-hot encoded.
    typedef enum logic [5:0] {
        PH_IDLE = 6'b000001,
        PH_HDR1 = 6'b000010,
        PH_HDR2 = 6'b000100,
        PH_LEN  = 6'b001000,
        PH_ERR  = 6'b010000,
        PH_BODY = 6'b100000
    } sspp_phase_t;

    // Result produced for one received byte.
    typedef struct packed {
        logic       byte_accepted;
        logic       param_valid;
        logic [7:0] param_index;
        logic [7:0] param_byte;
        logic       frame_done;
        logic       checksum_ok;
        logic [7:0] servo_id;
        logic [7:0] error_flags;
        logic [7:0] param_count;
    } sspp_result_t;

endpackage

`default_nettype wire

@@ rtl/core/servo_status_packet_parser_top.sv @@
// ----------------------------------------------------------------------------
// Servo status packet parser
// Parses servo status packets one received byte per request.
// ----------------------------------------------------------------------------
// Usage:
// Each input request carries one received byte on rx_byte (in_valid/in_ready).
// Every byte yields exactly one result request on the output channel
// (out_valid/out_ready): header acceptance, parameter byte with its index,
// frame done with checksum check, and the stored id, error and parameter count.
// From input acceptance to the result: the byte is registered in the input
// register, parsed by the state machine, and the result is registered in the
// result register, which drives out_valid and the result ports.
// Throughput is one byte per cycle while results are taken; the input and
// result registers let a new byte enter while a finished result waits to be taken.
// When the receiver stalls, the result register holds, the input register
// fills, and in_ready drops until the result is taken.
// Reset clears both stage valid flags and puts the parser in idle, waiting
// for the first header byte, with id, length, error, counter and sum at zero.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module servo_status_packet_parser_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] rx_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            byte_accepted,
    output logic            param_valid,
    output logic [7:0]      param_index,
    output logic [7:0]      param_byte,
    output logic            frame_done,
    output logic            checksum_ok,
    output logic [7:0]      servo_id,
    output logic [7:0]      error_flags,
    output logic [7:0]      param_count
);
    import sspp_pkg::*;

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         out_valid_reg;
    sspp_result_t out_reg;
    sspp_result_t result;
    logic         out_free;
    logic         advance;

    // Pipeline flow control.
    assign out_free = !out_valid_reg || out_ready;
    assign advance  = in_valid_reg && out_free;
    assign in_ready = !in_valid_reg || advance;

    // Input stage valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // Input byte register.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    sspp_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .result  (result)
    );

    // Result stage valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= result;
        end
    end

    // Output ports.
    assign out_valid     = out_valid_reg;
    assign byte_accepted = out_reg.byte_accepted;
    assign param_valid   = out_reg.param_valid;
    assign param_index   = out_reg.param_index;
    assign param_byte    = out_reg.param_byte;
    assign frame_done    = out_reg.frame_done;
    assign checksum_ok   = out_reg.checksum_ok;
    assign servo_id      = out_reg.servo_id;
    assign error_flags   = out_reg.error_flags;
    assign param_count   = out_reg.param_count;

    // A byte is either a parameter or the closing checksum, never both.
    `ASSERT_IMPL(a_param_not_done, clk, rst_n, out_valid_reg && out_reg.param_valid, !out_reg.frame_done)
    // A checksum match is only reported on a closing byte.
    `ASSERT_IMPL(a_ok_needs_done, clk, rst_n, out_valid_reg && out_reg.checksum_ok, out_reg.frame_done)
    // A rejected header byte carries no parameter and closes no frame.
    `ASSERT_IMPL(a_reject_clean, clk, rst_n, out_valid_reg && !out_reg.byte_accepted, !out_reg.param_valid && !out_reg.frame_done)
    // A held input byte is consumed as soon as the result stage frees up.
    `ASSERT_NEXT(a_drain, clk, rst_n, in_valid_reg && !out_valid_reg, out_valid_reg)

endmodule

`default_nettype wire

@@ rtl/core/sspp_parser.sv @@
// ----------------------------------------------------------------------------
// Servo status packet parser state machine
// Holds the packet state and forms the result for the byte presented.
// ----------------------------------------------------------------------------
`default_nettype none

module sspp_parser (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire logic [7:0]            rx_byte,
    output sspp_pkg::sspp_result_t     result
);
    import sspp_pkg::*;

    sspp_phase_t phase_reg, phase_next;
    logic [7:0]  id_reg, id_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  code_reg, code_next;
    logic [7:0]  cnt_reg, cnt_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  expected_cur;
    logic [7:0]  sum_add;

    // Parameter bytes carried by the current packet length.
    assign expected_cur = (len_reg > LEN_OVERHEAD) ? (len_reg - LEN_OVERHEAD) : 8'd0;
    assign sum_add      = sum_reg + rx_byte;

    // Next state and result for the presented byte.
    always_comb
    begin
        phase_next = phase_reg;
        id_next    = id_reg;
        len_next   = len_reg;
        code_next  = code_reg;
        cnt_next   = cnt_reg;
        sum_next   = sum_reg;

        result               = '0;
        result.byte_accepted = 1'b1;

        case (phase_reg)
            PH_IDLE:
            begin
                if (rx_byte == HEADER_BYTE)
                begin
                    phase_next = PH_HDR1;
                end
                else
                begin
                    result.byte_accepted = 1'b0;
                end
            end
            PH_HDR1:
            begin
                if (rx_byte == HEADER_BYTE)
                begin
                    phase_next = PH_HDR2;
                end
                else
                begin
                    result.byte_accepted = 1'b0;
                    phase_next           = PH_IDLE;
                end
            end
            PH_HDR2:
            begin
                id_next    = rx_byte;
                sum_next   = rx_byte;
                cnt_next   = 8'd0;
                phase_next = PH_LEN;
            end
            PH_LEN:
            begin
                len_next   = rx_byte;
                sum_next   = sum_add;
                phase_next = PH_ERR;
            end
            PH_ERR:
            begin
                code_next  = rx_byte;
                sum_next   = sum_add;
                cnt_next   = 8'd0;
                phase_next = PH_BODY;
            end
            PH_BODY:
            begin
                if (cnt_reg < expected_cur)
                begin
                    result.param_valid = 1'b1;
                    result.param_index = cnt_reg;
                    result.param_byte  = rx_byte;
                    sum_next           = sum_add;
                    cnt_next           = cnt_reg + 8'd1;
                end
                else
                begin
                    result.frame_done  = 1'b1;
                    result.checksum_ok = (~sum_reg == rx_byte);
                    cnt_next           = 8'd0;
                    phase_next         = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        // Stored fields are reported after this byte's update.
        result.servo_id    = id_next;
        result.error_flags = code_next;
        result.param_count = (len_next > LEN_OVERHEAD) ? (len_next - LEN_OVERHEAD) : 8'd0;
    end

    // Packet state registers, updated when a byte is consumed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            id_reg    <= 8'd0;
            len_reg   <= 8'd0;
            code_reg  <= 8'd0;
            cnt_reg   <= 8'd0;
            sum_reg   <= 8'd0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            id_reg    <= id_next;
            len_reg   <= len_next;
            code_reg  <= code_next;
            cnt_reg   <= cnt_next;
            sum_reg   <= sum_next;
        end
    end

endmodule

`default_nettype wire
